FILE: rtl/core/eiph_pkg.sv
// Package for the Ethernet/IP header parser: phase codes, verdicts, helpers.
// No dependencies.
package eiph_pkg;

  typedef enum logic [2:0] {
    PH_TYPE = 3'd0,
    PH_MPLS = 3'd1,
    PH_IP   = 3'd2,
    PH_EXT  = 3'd3,
    PH_L4   = 3'd4,
    PH_HOLD = 3'd5,
    PH_DROP = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    SEL_V4  = 2'd0,
    SEL_V6  = 2'd1,
    SEL_NIB = 2'd2
  } ip_sel_t;

  localparam logic [1:0] V_OK   = 2'd0;
  localparam logic [1:0] V_BAD  = 2'd1;
  localparam logic [1:0] V_FRAG = 2'd2;

  localparam logic [1:0] TR_TCP    = 2'd0;
  localparam logic [1:0] TR_UDP    = 2'd1;
  localparam logic [1:0] TR_ICMP   = 2'd2;
  localparam logic [1:0] TR_ICMPV6 = 2'd3;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_ICMP6 = 8'd58;
  localparam logic [7:0] PROTO_FRAG = 8'd44;

  localparam logic [15:0] ET_IPV4 = 16'h0800;
  localparam logic [15:0] ET_IPV6 = 16'h86dd;
  localparam logic [15:0] ET_VLAN = 16'h8100;
  localparam logic [15:0] ET_QINQ = 16'h88a8;
  localparam logic [15:0] ET_MPLS = 16'h8847;
  localparam logic [15:0] ET_MPLSM = 16'h8848;

  localparam logic [15:0] FRAG_MASK = 16'h3fff; // MF | fragment offset

  function automatic logic is_ext6(input logic [7:0] p);
    case (p)
      8'd0, 8'd43, 8'd44, 8'd50, 8'd51, 8'd60,
      8'd135, 8'd139, 8'd140, 8'd253, 8'd254: is_ext6 = 1'b1;
      default: is_ext6 = 1'b0;
    endcase
  endfunction

  function automatic logic is_l4v6(input logic [7:0] p);
    is_l4v6 = (p == PROTO_TCP) || (p == PROTO_UDP) || (p == PROTO_ICMP6);
  endfunction

  typedef struct packed {
    logic [1:0]  status;
    logic        ip_version;
    logic [1:0]  transport;
    logic [15:0] ip_offset;
    logic [15:0] transport_offset;
    logic [15:0] payload_offset;
    logic [15:0] ip_length;
    logic [63:0] timestamp_out;
  } result_t;

endpackage

FILE: rtl/core/eiph_if.sv
// Stream interfaces for the header parser: byte input beats and result beats.
// No dependencies.
interface eiph_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        frame_end;
  logic [63:0] arrival_time;
  modport source (output valid, data_byte, frame_end, arrival_time, input ready);
  modport sink   (input valid, data_byte, frame_end, arrival_time, output ready);
endinterface

interface eiph_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        ip_version;
  logic [1:0]  transport;
  logic [15:0] ip_offset;
  logic [15:0] transport_offset;
  logic [15:0] payload_offset;
  logic [15:0] ip_length;
  logic [63:0] timestamp_out;
  modport source (output valid, status, ip_version, transport, ip_offset,
                  transport_offset, payload_offset, ip_length, timestamp_out,
                  input ready);
  modport sink   (input valid, status, ip_version, transport, ip_offset,
                  transport_offset, payload_offset, ip_length, timestamp_out,
                  output ready);
endinterface

FILE: rtl/core/ethernet_ip_header_parser_core.sv
// Top level of the Ethernet/VLAN/MPLS/IPv4/IPv6 header parser.
// Depends on eiph_pkg, the stream interfaces in eiph_if.sv and eiph_parse_view.
//
//   channel  | dir | beat                                   | handshake
//   ---------+-----+----------------------------------------+------------
//   in_s     | in  | data_byte, frame_end, arrival_time     | valid/ready
//   out_s    | out | verdict, offsets, ip_length, timestamp | valid/ready
//
// One byte per cycle while input ready is high. A byte is folded into the
// parse state the cycle it is accepted; on the frame_end beat the verdict
// is formed in the same cycle and lands in a two-entry result skid
// (main + spare), so input keeps flowing while a result waits. Input ready
// drops only while the spare holds a result.
// Reset (rst, synchronous) returns the parser to the Ethernet type phase
// and empties the result skid.
module ethernet_ip_header_parser_core (
  input  logic clk,
  input  logic rst,
  eiph_in_if.sink    in_s,
  eiph_out_if.source out_s
);

  // ---- parse state ----
  logic [16:0]          byte_count;
  eiph_pkg::phase_t     parse_phase;
  logic [31:0]          field_shift;
  logic [15:0]          ip_start;
  logic [15:0]          header_end;
  logic [15:0]          ip_total_length;
  logic [15:0]          ext_remaining;
  logic [7:0]           next_proto;
  logic [15:0]          transport_field;
  logic [1:0]           verdict;
  logic [63:0]          frame_time;
  logic                 ip_v6;
  eiph_pkg::ip_sel_t    ip_select;

  logic [16:0]          byte_count_next;
  eiph_pkg::phase_t     parse_phase_next;
  logic [31:0]          field_shift_next;
  logic [15:0]          ip_start_next;
  logic [15:0]          header_end_next;
  logic [15:0]          ip_total_length_next;
  logic [15:0]          ext_remaining_next;
  logic [7:0]           next_proto_next;
  logic [15:0]          transport_field_next;
  logic [1:0]           verdict_next;
  logic [63:0]          frame_time_next;
  logic                 ip_v6_next;
  eiph_pkg::ip_sel_t    ip_select_next;

  // ---- result skid ----
  logic                 res_valid;
  logic                 spare_valid;
  eiph_pkg::result_t    res;
  eiph_pkg::result_t    spare;
  eiph_pkg::result_t    fin;

  logic accept;
  logic fire;

  // State after the byte step, as the verdict sees it.
  logic [16:0]       byte_count_next_pre;
  logic [15:0]       ip_start_n;
  logic [15:0]       header_end_n;
  logic [15:0]       ip_total_length_n;
  logic [15:0]       transport_field_n;
  logic [7:0]        proto_n;
  logic [1:0]        verdict_n;
  eiph_pkg::phase_t  phase_n;
  logic              v6_n;

  assign in_s.ready = !spare_valid;
  assign accept     = in_s.valid && in_s.ready;
  assign fire       = accept && in_s.frame_end;

  // Byte-level parse step: positions and marks are all 17 bits wide so the
  // "beyond 65535" checks fall out of the top bit. Field reads use the shift
  // register with the current byte already shifted in.
  logic        counting;
  logic [16:0] pos;
  logic [7:0]  b;
  logic [31:0] sh;
  logic [15:0] et;
  logic [16:0] ip_off;
  logic [15:0] ip_o16;
  logic [16:0] l4_base;
  logic [16:0] l4_off;
  logic [16:0] mark;
  logic [19:0] label;
  logic        v6_now;
  logic [15:0] hl_now;
  logic [11:0] extlen;
  logic [15:0] plen;

  always_comb begin
    byte_count_next      = byte_count;
    parse_phase_next     = parse_phase;
    field_shift_next     = field_shift;
    ip_start_next        = ip_start;
    header_end_next      = header_end;
    ip_total_length_next = ip_total_length;
    ext_remaining_next   = ext_remaining;
    next_proto_next      = next_proto;
    transport_field_next = transport_field;
    verdict_next         = verdict;
    frame_time_next      = frame_time;
    ip_v6_next           = ip_v6;
    ip_select_next       = ip_select;

    pos      = byte_count;
    b        = in_s.data_byte;
    sh       = {field_shift[23:0], b};
    counting = !byte_count[16];
    et       = sh[15:0];
    ip_off   = pos - {1'b0, ip_start};
    ip_o16   = ip_off[15:0];
    l4_base  = {1'b0, ip_start} + {1'b0, header_end};
    l4_off   = pos - l4_base;
    mark     = '0;
    label    = sh[23:4];
    v6_now   = ip_v6;
    hl_now   = header_end;
    extlen   = ({4'd0, b} + 12'd1) << 3;
    plen     = sh[15:0];

    if (accept) begin
      if (byte_count == '0) frame_time_next = in_s.arrival_time;
      if (counting) begin
        field_shift_next = sh;
        byte_count_next  = byte_count + 17'd1;
        if (verdict != eiph_pkg::V_BAD) begin
          case (parse_phase)
            eiph_pkg::PH_TYPE: begin
              if (pos == {1'b0, header_end}) begin
                if (et == eiph_pkg::ET_IPV4 || et == eiph_pkg::ET_IPV6) begin
                  mark = pos + 17'd1;
                  if (mark[16]) begin
                    verdict_next = eiph_pkg::V_BAD;
                    parse_phase_next = eiph_pkg::PH_DROP;
                  end else begin
                    ip_start_next = mark[15:0];
                    ip_select_next = (et == eiph_pkg::ET_IPV4) ? eiph_pkg::SEL_V4
                                                               : eiph_pkg::SEL_V6;
                    parse_phase_next = eiph_pkg::PH_IP;
                  end
                end else if (et == eiph_pkg::ET_VLAN || et == eiph_pkg::ET_QINQ ||
                             et == eiph_pkg::ET_MPLS || et == eiph_pkg::ET_MPLSM) begin
                  if (et == eiph_pkg::ET_MPLS || et == eiph_pkg::ET_MPLSM) begin
                    mark = pos + 17'd3;
                    parse_phase_next = eiph_pkg::PH_MPLS;
                  end else begin
                    mark = pos + 17'd4;
                  end
                  if (mark[16]) begin
                    verdict_next = eiph_pkg::V_BAD;
                    parse_phase_next = eiph_pkg::PH_DROP;
                  end else begin
                    header_end_next = mark[15:0];
                  end
                end else begin
                  verdict_next = eiph_pkg::V_BAD;
                  parse_phase_next = eiph_pkg::PH_DROP;
                end
              end
            end
            eiph_pkg::PH_MPLS: begin
              if (pos == {1'b0, header_end}) begin
                if (!b[0]) begin
                  mark = pos + 17'd4;
                  if (mark[16]) begin
                    verdict_next = eiph_pkg::V_BAD;
                    parse_phase_next = eiph_pkg::PH_DROP;
                  end else begin
                    header_end_next = mark[15:0];
                  end
                end else begin
                  mark = pos + 17'd2;
                  if (mark[16]) begin
                    verdict_next = eiph_pkg::V_BAD;
                    parse_phase_next = eiph_pkg::PH_DROP;
                  end else begin
                    ip_start_next = mark[15:0];
                    parse_phase_next = eiph_pkg::PH_IP;
                    if (label == 20'd0)      ip_select_next = eiph_pkg::SEL_V4;
                    else if (label == 20'd2) ip_select_next = eiph_pkg::SEL_V6;
                    else                     ip_select_next = eiph_pkg::SEL_NIB;
                  end
                end
              end
            end
            eiph_pkg::PH_IP: begin
              if (!ip_off[16]) begin
                if (ip_o16 == 16'd0) begin
                  if (ip_select == eiph_pkg::SEL_NIB) begin
                    if (b[7:4] == 4'h4)      v6_now = 1'b0;
                    else if (b[7:4] == 4'h6) v6_now = 1'b1;
                    else begin
                      verdict_next = eiph_pkg::V_BAD;
                      parse_phase_next = eiph_pkg::PH_DROP;
                    end
                  end else begin
                    v6_now = (ip_select == eiph_pkg::SEL_V6);
                  end
                  ip_v6_next = v6_now;
                  if (!v6_now) begin
                    hl_now = {10'd0, b[3:0], 2'b00};
                    header_end_next = hl_now;
                  end
                end
                if (verdict_next != eiph_pkg::V_BAD) begin
                  if (!v6_now) begin
                    if (ip_o16 == 16'd3) ip_total_length_next = sh[15:0];
                    if (ip_o16 == 16'd7 && (sh[15:0] & eiph_pkg::FRAG_MASK) != '0)
                      verdict_next = eiph_pkg::V_FRAG;
                    if (ip_o16 == 16'd9) next_proto_next = b;
                    if (ip_o16 == 16'd19) begin
                      if (hl_now < 16'd20) begin
                        verdict_next = eiph_pkg::V_BAD;
                        parse_phase_next = eiph_pkg::PH_DROP;
                      end else if (verdict == eiph_pkg::V_FRAG) begin
                        parse_phase_next = eiph_pkg::PH_HOLD;
                      end else if (next_proto == eiph_pkg::PROTO_TCP ||
                                   next_proto == eiph_pkg::PROTO_UDP ||
                                   next_proto == eiph_pkg::PROTO_ICMP) begin
                        parse_phase_next = eiph_pkg::PH_L4;
                      end else begin
                        verdict_next = eiph_pkg::V_BAD;
                        parse_phase_next = eiph_pkg::PH_DROP;
                      end
                    end
                  end else begin
                    if (ip_o16 == 16'd5) begin
                      if (plen > 16'hffd7) begin
                        verdict_next = eiph_pkg::V_BAD;
                        parse_phase_next = eiph_pkg::PH_DROP;
                      end else begin
                        ext_remaining_next   = plen;
                        ip_total_length_next = plen + 16'd40;
                      end
                    end
                    if (ip_o16 == 16'd6) next_proto_next = b;
                    if (ip_o16 == 16'd39) begin
                      header_end_next = 16'd40;
                      if (eiph_pkg::is_l4v6(next_proto))
                        parse_phase_next = eiph_pkg::PH_L4;
                      else if (eiph_pkg::is_ext6(next_proto) && ext_remaining >= 16'd2)
                        parse_phase_next = eiph_pkg::PH_EXT;
                      else begin
                        verdict_next = eiph_pkg::V_BAD;
                        parse_phase_next = eiph_pkg::PH_DROP;
                      end
                    end
                  end
                end
              end
            end
            eiph_pkg::PH_EXT, eiph_pkg::PH_L4: begin
              if (pos >= l4_base) begin
                if (parse_phase == eiph_pkg::PH_EXT) begin
                  if (l4_off == 17'd1) begin
                    if ({4'd0, extlen} > ext_remaining) begin
                      verdict_next = eiph_pkg::V_BAD;
                      parse_phase_next = eiph_pkg::PH_DROP;
                    end else if (next_proto == eiph_pkg::PROTO_FRAG) begin
                      verdict_next = eiph_pkg::V_FRAG;
                      parse_phase_next = eiph_pkg::PH_HOLD;
                    end else begin
                      ext_remaining_next = ext_remaining - {4'd0, extlen};
                      next_proto_next    = sh[15:8];
                      header_end_next    = header_end + {4'd0, extlen};
                      if (eiph_pkg::is_ext6(sh[15:8]))
                        parse_phase_next = eiph_pkg::PH_EXT;
                      else if (eiph_pkg::is_l4v6(sh[15:8]))
                        parse_phase_next = eiph_pkg::PH_L4;
                      else begin
                        verdict_next = eiph_pkg::V_BAD;
                        parse_phase_next = eiph_pkg::PH_DROP;
                      end
                    end
                  end
                end else if (next_proto == eiph_pkg::PROTO_TCP && l4_off == 17'd12) begin
                  transport_field_next = {12'd0, b[7:4]};
                end else if (next_proto == eiph_pkg::PROTO_UDP && l4_off == 17'd5) begin
                  transport_field_next = sh[15:0];
                end
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  eiph_parse_view u_view (
    .byte_count (byte_count), .counting (counting),
    .p_phase (parse_phase_next),
    .p_ip_start (ip_start_next), .p_header_end (header_end_next),
    .p_total (ip_total_length_next), .p_tfield (transport_field_next),
    .p_proto (next_proto_next), .p_verdict (verdict_next), .p_v6 (ip_v6_next),
    .o_phase (phase_n), .o_ip_start (ip_start_n), .o_header_end (header_end_n),
    .o_total (ip_total_length_n), .o_tfield (transport_field_n),
    .o_proto (proto_n), .o_verdict (verdict_n), .o_v6 (v6_n),
    .o_count (byte_count_next_pre)
  );

  // Verdict, formed from the state as updated by the last byte.
  logic [16:0] lenip;
  logic [15:0] tl;
  logic [17:0] th;
  logic        ok;
  always_comb begin
    fin = '0;
    fin.status = eiph_pkg::V_BAD;
    fin.timestamp_out = frame_time_next;
    lenip = byte_count_next_pre - {1'b0, ip_start_n};
    tl    = ip_total_length_n - header_end_n;
    th    = {transport_field_n, 2'b00};
    ok = verdict_n != eiph_pkg::V_BAD && !byte_count_next_pre[16] &&
         (phase_n == eiph_pkg::PH_L4 || phase_n == eiph_pkg::PH_HOLD) &&
         byte_count_next_pre > {1'b0, ip_start_n};
    if (ok) begin
      if (!v6_n)
        ok = lenip > 17'd20 && {1'b0, header_end_n} < lenip &&
             lenip >= {1'b0, ip_total_length_n};
      else
        ok = lenip > 17'd40 && {1'b0, ip_total_length_n} <= lenip;
    end
    if (ok) begin
      if (phase_n == eiph_pkg::PH_HOLD) begin
        fin.status     = eiph_pkg::V_FRAG;
        fin.ip_version = v6_n;
        fin.ip_offset  = ip_start_n;
        fin.ip_length  = ip_total_length_n;
      end else if (ip_total_length_n >= header_end_n) begin
        fin.ip_version       = v6_n;
        fin.ip_offset        = ip_start_n;
        fin.transport_offset = header_end_n;
        fin.ip_length        = ip_total_length_n;
        if (proto_n == eiph_pkg::PROTO_TCP) begin
          if (tl >= 16'd20 && th >= 18'd20 && th <= {2'b00, tl}) begin
            fin.status = eiph_pkg::V_OK;
            fin.transport = eiph_pkg::TR_TCP;
            fin.payload_offset = header_end_n + th[15:0];
          end
        end else if (proto_n == eiph_pkg::PROTO_UDP) begin
          if (tl >= 16'd8 && tl == transport_field_n) begin
            fin.status = eiph_pkg::V_OK;
            fin.transport = eiph_pkg::TR_UDP;
            fin.payload_offset = header_end_n + 16'd8;
          end
        end else if (tl >= 16'd8) begin
          fin.status = eiph_pkg::V_OK;
          fin.transport = v6_n ? eiph_pkg::TR_ICMPV6 : eiph_pkg::TR_ICMP;
          fin.payload_offset = header_end_n + 16'd8;
        end
        if (fin.status == eiph_pkg::V_BAD) begin
          fin = '0;
          fin.status = eiph_pkg::V_BAD;
          fin.timestamp_out = frame_time_next;
        end
      end
    end
  end

  // The frame_end beat clears the parse state for the next frame; the frame
  // time is kept until the next first byte reloads it.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      parse_phase     <= eiph_pkg::PH_TYPE;
      field_shift     <= '0;
      ip_start        <= '0;
      header_end      <= 16'd13;
      ip_total_length <= '0;
      ext_remaining   <= '0;
      next_proto      <= '0;
      transport_field <= '0;
      verdict         <= eiph_pkg::V_OK;
      frame_time      <= '0;
      ip_v6           <= 1'b0;
      ip_select       <= eiph_pkg::SEL_V4;
    end else if (fire) begin
      byte_count      <= '0;
      parse_phase     <= eiph_pkg::PH_TYPE;
      field_shift     <= '0;
      ip_start        <= '0;
      header_end      <= 16'd13;
      ip_total_length <= '0;
      ext_remaining   <= '0;
      next_proto      <= '0;
      transport_field <= '0;
      verdict         <= eiph_pkg::V_OK;
      frame_time      <= frame_time_next;
      ip_v6           <= 1'b0;
      ip_select       <= eiph_pkg::SEL_V4;
    end else begin
      byte_count      <= byte_count_next;
      parse_phase     <= parse_phase_next;
      field_shift     <= field_shift_next;
      ip_start        <= ip_start_next;
      header_end      <= header_end_next;
      ip_total_length <= ip_total_length_next;
      ext_remaining   <= ext_remaining_next;
      next_proto      <= next_proto_next;
      transport_field <= transport_field_next;
      verdict         <= verdict_next;
      frame_time      <= frame_time_next;
      ip_v6           <= ip_v6_next;
      ip_select       <= ip_select_next;
    end
  end

  // Result skid: main register feeds the port, spare catches a result that
  // arrives while the main one is stalled.
  logic pop;
  assign pop = res_valid && out_s.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else begin
      if (!res_valid || pop) begin
        if (spare_valid) begin
          res         <= spare;
          res_valid   <= 1'b1;
          spare_valid <= fire;
          spare       <= fin;
        end else begin
          res_valid <= fire;
          res       <= fin;
        end
      end else if (fire) begin
        spare_valid <= 1'b1;
        spare       <= fin;
      end
    end
  end

  assign out_s.valid            = res_valid;
  assign out_s.status           = res.status;
  assign out_s.ip_version       = res.ip_version;
  assign out_s.transport        = res.transport;
  assign out_s.ip_offset        = res.ip_offset;
  assign out_s.transport_offset = res.transport_offset;
  assign out_s.payload_offset   = res.payload_offset;
  assign out_s.ip_length        = res.ip_length;
  assign out_s.timestamp_out    = res.timestamp_out;

endmodule

FILE: rtl/core/eiph_parse_view.sv
// Post-byte parse state handed to the end-of-frame verdict.
// Depends on eiph_pkg.
module eiph_parse_view (
  input  logic [16:0]      byte_count,
  input  logic             counting,
  input  eiph_pkg::phase_t p_phase,
  input  logic [15:0]      p_ip_start,
  input  logic [15:0]      p_header_end,
  input  logic [15:0]      p_total,
  input  logic [15:0]      p_tfield,
  input  logic [7:0]       p_proto,
  input  logic [1:0]       p_verdict,
  input  logic             p_v6,
  output eiph_pkg::phase_t o_phase,
  output logic [15:0]      o_ip_start,
  output logic [15:0]      o_header_end,
  output logic [15:0]      o_total,
  output logic [15:0]      o_tfield,
  output logic [7:0]       o_proto,
  output logic [1:0]       o_verdict,
  output logic             o_v6,
  output logic [16:0]      o_count
);
  // Byte count including the current byte, held at the limit once reached.
  assign o_phase      = p_phase;
  assign o_ip_start   = p_ip_start;
  assign o_header_end = p_header_end;
  assign o_total      = p_total;
  assign o_tfield     = p_tfield;
  assign o_proto      = p_proto;
  assign o_verdict    = p_verdict;
  assign o_v6         = p_v6;
  assign o_count      = counting ? byte_count + 17'd1 : byte_count;
endmodule

FILE: rtl/core/eiph_checker.sv
// Port-level checker for the header parser, bound to the top level.
// Depends on eiph_pkg.
module eiph_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [1:0]  out_transport,
  input logic [15:0] out_ip_offset
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_status != 2'd3) else $error("bad status");
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == eiph_pkg::V_BAD |-> out_ip_offset == '0 &&
    out_transport == '0) else $error("reject not zeroed");
  a_emit: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_end |=> out_valid) else $error("no result");
endmodule

bind ethernet_ip_header_parser_core eiph_checker u_chk (
  .clk (clk), .rst (rst),
  .in_valid (in_s.valid), .in_ready (in_s.ready), .in_end (in_s.frame_end),
  .out_valid (out_s.valid), .out_ready (out_s.ready),
  .out_status (out_s.status), .out_transport (out_s.transport),
  .out_ip_offset (out_s.ip_offset)
);
